>>> hdl/pfd_pkg.sv
// Package of the preamble frame deframer: result codes, result type and register map.
package pfd_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned SeqW = 16;
  localparam int unsigned LenW = 32;
  localparam int unsigned EventW = 3;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  localparam logic [DataW-1:0] PreambleReset = 8'h2A;

  // Register index of the preamble value.
  localparam logic [0:0] RegPreamble = 1'b0;

  typedef enum logic [EventW-1:0] {
    EvHeartbeat   = 3'd0,
    EvEmptyData   = 3'd1,
    EvPayload     = 3'd2,
    EvBadPreamble = 3'd3,
    EvBadKind     = 3'd4
  } event_e;

  typedef struct packed {
    event_e            event_res;
    logic              frame_kind;
    logic [SeqW-1:0]   seq_number;
    logic [LenW-1:0]   payload_length;
    logic [DataW-1:0]  payload_byte;
    logic              last_of_frame;
  } result_t;

endpackage

>>> hdl/pfd_cfg_regs.sv
// APB-style configuration register block holding the preamble value.
module pfd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfd_pkg::PaddrW-1:0]    paddr,
  input  logic [pfd_pkg::PdataW-1:0]    pwdata,
  output logic [pfd_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  output logic [pfd_pkg::DataW-1:0]     preamble_o
);

  logic [pfd_pkg::DataW-1:0] preamble_q, preamble_d;
  logic                      reg_hit;

  // Bit 2 of the byte address selects the register; only index zero exists.
  assign reg_hit = (paddr[pfd_pkg::PaddrW-1] == pfd_pkg::RegPreamble);
  assign pready  = 1'b1;

  always_comb begin
    preamble_d = preamble_q;
    if (psel && penable && pwrite && reg_hit) begin
      preamble_d = pwdata[pfd_pkg::DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= pfd_pkg::PreambleReset;
    end else begin
      preamble_q <= preamble_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(pfd_pkg::PdataW-pfd_pkg::DataW){1'b0}}, preamble_q};
    end
  end

  assign preamble_o = preamble_q;

endmodule

>>> hdl/pfd_parser.sv
// Frame parser: per-byte state update and result formation.
module pfd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [pfd_pkg::DataW-1:0]  data_byte_i,
  input  logic [pfd_pkg::DataW-1:0]  preamble_i,
  output logic                       res_valid_o,
  output pfd_pkg::result_t           res_o
);

  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhKind    = 3'd1,
    PhSeq     = 3'd2,
    PhLen     = 3'd3,
    PhPayload = 3'd4
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [1:0]                 idx_q, idx_d;
  logic                       kind_q, kind_d;
  logic [pfd_pkg::SeqW-1:0]   seq_q, seq_d;
  logic [pfd_pkg::LenW-1:0]   len_q, len_d;
  logic [pfd_pkg::LenW-1:0]   remain_q, remain_d;
  logic [pfd_pkg::LenW-1:0]   len_full;
  logic [pfd_pkg::SeqW-1:0]   seq_full;
  logic                       last_byte;

  assign seq_full  = {data_byte_i, seq_q[pfd_pkg::DataW-1:0]};
  assign len_full  = {data_byte_i, len_q[23:0]};
  assign last_byte = (remain_q <= 32'd1);

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    kind_d      = kind_q;
    seq_d       = seq_q;
    len_d       = len_q;
    remain_d    = remain_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.event_res = pfd_pkg::EvBadPreamble;
    case (phase_q)
      PhHunt: begin
        if (data_byte_i != preamble_i) begin
          res_valid_o     = 1'b1;
          res_o.event_res = pfd_pkg::EvBadPreamble;
        end else begin
          kind_d   = 1'b0;
          seq_d    = '0;
          len_d    = '0;
          remain_d = '0;
          idx_d    = 2'd0;
          phase_d  = PhKind;
        end
      end
      PhKind: begin
        idx_d = 2'd0;
        if (data_byte_i > 8'd1) begin
          phase_d         = PhHunt;
          res_valid_o     = 1'b1;
          res_o.event_res = pfd_pkg::EvBadKind;
        end else begin
          kind_d  = data_byte_i[0];
          phase_d = PhSeq;
        end
      end
      PhSeq: begin
        if (idx_q == 2'd0) begin
          seq_d = {{(pfd_pkg::SeqW-pfd_pkg::DataW){1'b0}}, data_byte_i};
          idx_d = 2'd1;
        end else begin
          seq_d = seq_full;
          idx_d = 2'd0;
          if (!kind_q) begin
            phase_d              = PhHunt;
            res_valid_o          = 1'b1;
            res_o.event_res      = pfd_pkg::EvHeartbeat;
            res_o.seq_number     = seq_full;
            res_o.last_of_frame  = 1'b1;
          end else begin
            len_d   = '0;
            phase_d = PhLen;
          end
        end
      end
      PhLen: begin
        case (idx_q)
          2'd0:    len_d[7:0]   = data_byte_i;
          2'd1:    len_d[15:8]  = data_byte_i;
          2'd2:    len_d[23:16] = data_byte_i;
          default: len_d        = len_full;
        endcase
        if (idx_q != 2'd3) begin
          idx_d = idx_q + 2'd1;
        end else begin
          idx_d = 2'd0;
          if (len_full == '0) begin
            phase_d             = PhHunt;
            res_valid_o         = 1'b1;
            res_o.event_res     = pfd_pkg::EvEmptyData;
            res_o.frame_kind    = 1'b1;
            res_o.seq_number    = seq_q;
            res_o.last_of_frame = 1'b1;
          end else begin
            remain_d = len_full;
            phase_d  = PhPayload;
          end
        end
      end
      PhPayload: begin
        res_valid_o          = 1'b1;
        res_o.event_res      = pfd_pkg::EvPayload;
        res_o.frame_kind     = kind_q;
        res_o.seq_number     = seq_q;
        res_o.payload_length = len_q;
        res_o.payload_byte   = data_byte_i;
        res_o.last_of_frame  = last_byte;
        if (last_byte) begin
          remain_d = '0;
          phase_d  = PhHunt;
        end else begin
          remain_d = remain_q - 32'd1;
        end
      end
      default: begin
        phase_d = PhHunt;
        idx_d   = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      idx_q    <= 2'd0;
      kind_q   <= 1'b0;
      seq_q    <= '0;
      len_q    <= '0;
      remain_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      kind_q   <= kind_d;
      seq_q    <= seq_d;
      len_q    <= len_d;
      remain_q <= remain_d;
    end
  end

endmodule

>>> hdl/pfd_out_reg.sv
// Result register that holds one result until the downstream side takes it.
module pfd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  pfd_pkg::result_t  res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              free_o,
  output pfd_pkg::result_t  res_o
);

  logic             valid_q, valid_d;
  pfd_pkg::result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> hdl/preamble_frame_deframer_top.sv
// Top level of the preamble frame deframer: byte stream in, frame events out.
//
// The deframer takes one received byte per transfer on the input channel and
// sustains one byte per clock cycle. Each byte passes through the frame
// parser, whose state registers (phase, field byte index, held kind, sequence
// number, payload length and remaining byte count) update in the cycle the
// byte is taken; any result it causes is captured in a single output register
// at that same edge and appears on the output channel in the next cycle. The
// input stays ready while that register is empty or is being emptied in the
// same cycle, so a stalled output blocks input only while a result waits.
// Header bytes (preamble, kind, sequence number, length) cause no result
// except on completion of a heartbeat frame, an empty data frame, or an
// error. A byte that does not match the preamble while hunting gives a bad
// preamble event; a kind byte above one gives a bad kind event and the parser
// returns to hunting. Every payload byte of a data frame gives one payload
// event, the last marked with last_of_frame. The preamble value lives at byte
// address 0 of the configuration port and resets to 0x2A; it should be
// written only while the block is idle.
module preamble_frame_deframer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfd_pkg::PaddrW-1:0]   paddr,
  input  logic [pfd_pkg::PdataW-1:0]   pwdata,
  output logic [pfd_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  // Input byte channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pfd_pkg::DataW-1:0]    data_byte_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pfd_pkg::EventW-1:0]   event_res_o,
  output logic                         frame_kind_o,
  output logic [pfd_pkg::SeqW-1:0]     seq_number_o,
  output logic [pfd_pkg::LenW-1:0]     payload_length_o,
  output logic [pfd_pkg::DataW-1:0]    payload_byte_o,
  output logic                         last_of_frame_o
);

  logic [pfd_pkg::DataW-1:0] preamble;
  logic                      step;
  logic                      res_valid;
  logic                      out_free;
  pfd_pkg::result_t          res_next;
  pfd_pkg::result_t          res_held;

  pfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .preamble_o (preamble)
  );

  // A byte is taken whenever the output register can accept a result.
  assign in_ready_o = out_free;
  assign step       = in_valid_i && out_free;

  pfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (data_byte_i),
    .preamble_i  (preamble),
    .res_valid_o (res_valid),
    .res_o       (res_next)
  );

  pfd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res_next),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .res_o       (res_held)
  );

  assign event_res_o      = res_held.event_res;
  assign frame_kind_o     = res_held.frame_kind;
  assign seq_number_o     = res_held.seq_number;
  assign payload_length_o = res_held.payload_length;
  assign payload_byte_o   = res_held.payload_byte;
  assign last_of_frame_o  = res_held.last_of_frame;

endmodule
